// File: hdl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared constants, codes and types of the distance vector route table.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

   localparam int ROUTES = 32;
   localparam int IDX_W  = $clog2(ROUTES);
   localparam int CNT_W  = $clog2(ROUTES + 1);

   localparam logic [15:0] EXPIRE_RESET = 16'd100;

   // input opcodes
   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_SWEEP  = 2'd2;
   localparam logic [1:0] OP_DUMP   = 2'd3;

   // result status codes
   localparam logic [3:0] ST_ADDED     = 4'd0;
   localparam logic [3:0] ST_REPLACED  = 4'd1;
   localparam logic [3:0] ST_REFRESHED = 4'd2;
   localparam logic [3:0] ST_KEPT      = 4'd3;
   localparam logic [3:0] ST_FULL      = 4'd4;
   localparam logic [3:0] ST_TICK      = 4'd5;
   localparam logic [3:0] ST_SWEPT     = 4'd6;
   localparam logic [3:0] ST_ENTRY     = 4'd7;
   localparam logic [3:0] ST_EMPTY     = 4'd8;

   typedef struct packed {
      logic [63:0] prefix;
      logic [63:0] gw_high;
      logic [63:0] gw_low;
      logic [31:0] metric;
      logic [31:0] stamp;
      logic        direct;
   } row_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       clear_ptrs;
      logic       read_row;
      logic       next_row;
      logic       upd_write;
      logic       upd_new_stamp;
      logic       append;
      logic       tick;
      logic       sweep_drop;
      logic       sweep_keep;
      logic       sweep_done;
      logic       status_we;
      logic [3:0] status;
      logic       emit_single;
      logic       emit_entry;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       count_zero;
      logic       full;
      logic       last_row;
      logic       match;
      logic       met_lt;
      logic       met_eq;
      logic       expired;
      logic       out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: hdl/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer for update scan, tick, sweep compaction and dump.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dvrt_pkg::sts_type sts,
   output dvrt_pkg::cmd_type      cmd
);
   import dvrt_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SCAN_RD = 4'd1;
   localparam logic [3:0] S_SCAN_EV = 4'd2;
   localparam logic [3:0] S_SW_RD   = 4'd3;
   localparam logic [3:0] S_SW_EV   = 4'd4;
   localparam logic [3:0] S_SW_FIN  = 4'd5;
   localparam logic [3:0] S_DM_RD   = 4'd6;
   localparam logic [3:0] S_DM_EV   = 4'd7;
   localparam logic [3:0] S_OUT     = 4'd8;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req   = 1'b1;
               cmd.clear_ptrs = 1'b1;
               unique case (sts.opcode)
                  OP_UPDATE: state_in = S_SCAN_RD;
                  OP_TICK: begin
                     cmd.tick      = 1'b1;
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_TICK;
                     state_in      = S_OUT;
                  end
                  OP_SWEEP: state_in = sts.count_zero ? S_SW_FIN : S_SW_RD;
                  OP_DUMP: begin
                     if (sts.count_zero) begin
                        cmd.status_we = 1'b1;
                        cmd.status    = ST_EMPTY;
                        state_in      = S_OUT;
                     end else begin
                        state_in = S_DM_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN_RD: begin
            if (sts.count_zero) begin
               cmd.status_we = 1'b1;
               cmd.status    = ST_ADDED;
               cmd.append    = 1'b1;
               state_in      = S_OUT;
            end else begin
               cmd.read_row = 1'b1;
               state_in     = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.status_we = 1'b1;
            if (sts.match) begin
               state_in = S_OUT;
               if (sts.met_lt) begin
                  cmd.upd_write     = 1'b1;
                  cmd.upd_new_stamp = 1'b1;
                  cmd.status        = ST_REPLACED;
               end else if (sts.met_eq) begin
                  cmd.upd_write = 1'b1;
                  cmd.status    = ST_REFRESHED;
               end else begin
                  cmd.status = ST_KEPT;
               end
            end else if (sts.last_row) begin
               state_in = S_OUT;
               if (sts.full) begin
                  cmd.status = ST_FULL;
               end else begin
                  cmd.append = 1'b1;
                  cmd.status = ST_ADDED;
               end
            end else begin
               cmd.status_we = 1'b0;
               cmd.next_row  = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SW_RD: begin
            cmd.read_row = 1'b1;
            state_in     = S_SW_EV;
         end
         S_SW_EV: begin
            cmd.sweep_drop = sts.expired;
            cmd.sweep_keep = !sts.expired;
            cmd.next_row   = 1'b1;
            state_in       = sts.last_row ? S_SW_FIN : S_SW_RD;
         end
         S_SW_FIN: begin
            cmd.sweep_done = 1'b1;
            cmd.status_we  = 1'b1;
            cmd.status     = ST_SWEPT;
            state_in       = S_OUT;
         end
         S_DM_RD: begin
            cmd.read_row = 1'b1;
            state_in     = S_DM_EV;
         end
         S_DM_EV: begin
            if (sts.out_free) begin
               cmd.emit_entry = 1'b1;
               cmd.next_row   = 1'b1;
               state_in       = sts.last_row ? S_IDLE : S_DM_RD;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/dvrt_dp.sv
// ----------------------------------------------------------------------------
// dvrt_dp
// Route memory, pointers, seconds counter, expiry register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_opcode,
   input  wire dvrt_pkg::row_type req_row,
   input  wire logic              csr_we,
   input  wire logic [15:0]       csr_data,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [3:0]             rsp_status,
   output dvrt_pkg::row_type      rsp_row,
   output logic [31:0]            rsp_age,
   output logic [dvrt_pkg::CNT_W-1:0] rsp_count,
   output logic [dvrt_pkg::CNT_W-1:0] rsp_removed,
   output logic                   rsp_last,
   input  wire dvrt_pkg::cmd_type cmd,
   output dvrt_pkg::sts_type      sts
);
   import dvrt_pkg::*;

   row_type          mem [ROUTES];
   row_type          req_ff;
   row_type          rd_ff;
   logic [1:0]       op_ff;
   logic [CNT_W-1:0] idx_ff, wr_ff, removed_ff, count_ff;
   logic [31:0]      seconds_ff;
   logic [15:0]      expire_ff;
   logic [3:0]       status_ff;
   logic [31:0]      rd_age;

   logic             out_valid_ff;
   logic [3:0]       out_status_ff;
   row_type          out_row_ff;
   logic [31:0]      out_age_ff;
   logic [CNT_W-1:0] out_count_ff, out_removed_ff;
   logic             out_last_ff;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   row_type          mem_wdata;

   assign rd_age = seconds_ff - rd_ff.stamp;

   // status towards the sequencer
   always_comb begin
      sts.opcode     = req_opcode;
      sts.count_zero = (count_ff == '0);
      sts.full       = (count_ff == CNT_W'(ROUTES));
      sts.last_row   = (idx_ff + CNT_W'(1) == count_ff);
      sts.match      = (rd_ff.prefix == req_ff.prefix);
      sts.met_lt     = (req_ff.metric < rd_ff.metric);
      sts.met_eq     = (req_ff.metric == rd_ff.metric);
      sts.expired    = !rd_ff.direct && (rd_age > {16'd0, expire_ff});
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   // select memory write
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IDX_W-1:0];
      mem_wdata = req_ff;
      if (cmd.upd_write) begin
         mem_we = 1'b1;
         mem_wdata.stamp = cmd.upd_new_stamp ? seconds_ff : rd_ff.stamp;
      end else if (cmd.append) begin
         mem_we          = 1'b1;
         mem_waddr       = count_ff[IDX_W-1:0];
         mem_wdata.stamp = seconds_ff;
      end else if (cmd.sweep_keep) begin
         mem_we    = 1'b1;
         mem_waddr = wr_ff[IDX_W-1:0];
         mem_wdata = rd_ff;
      end
   end

   // route memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read_row) begin
         rd_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   // latch request payload and status
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_row;
         op_ff  <= req_opcode;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status;
      end
   end

   // pointers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         seconds_ff <= '0;
         expire_ff  <= EXPIRE_RESET;
         idx_ff     <= '0;
         wr_ff      <= '0;
         removed_ff <= '0;
      end else begin
         if (csr_we) begin
            expire_ff <= csr_data;
         end
         if (cmd.clear_ptrs) begin
            idx_ff     <= '0;
            wr_ff      <= '0;
            removed_ff <= '0;
         end else begin
            if (cmd.next_row) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
            if (cmd.sweep_keep) begin
               wr_ff <= wr_ff + CNT_W'(1);
            end
            if (cmd.sweep_drop) begin
               removed_ff <= removed_ff + CNT_W'(1);
            end
         end
         if (cmd.tick) begin
            seconds_ff <= seconds_ff + 32'd1;
         end
         if (cmd.append) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.sweep_done) begin
            count_ff <= wr_ff;
         end
      end
   end

   // result register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_single || cmd.emit_entry) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_single) begin
         out_status_ff  <= status_ff;
         out_row_ff     <= '0;
         out_age_ff     <= '0;
         out_count_ff   <= count_ff;
         out_removed_ff <= (op_ff == OP_SWEEP) ? removed_ff : '0;
         out_last_ff    <= 1'b1;
      end else if (cmd.emit_entry) begin
         out_status_ff  <= ST_ENTRY;
         out_row_ff     <= '{prefix: rd_ff.prefix, gw_high: rd_ff.gw_high,
                             gw_low: rd_ff.gw_low, metric: rd_ff.metric,
                             stamp: 32'd0, direct: rd_ff.direct};
         out_age_ff     <= rd_age;
         out_count_ff   <= count_ff;
         out_removed_ff <= '0;
         out_last_ff    <= sts.last_row;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_row     = out_row_ff;
   assign rsp_age     = out_age_ff;
   assign rsp_count   = out_count_ff;
   assign rsp_removed = out_removed_ff;
   assign rsp_last    = out_last_ff;

endmodule

`default_nettype wire

// File: hdl/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route table of up to 32 IPv6 prefixes with metric update, ageing and dump.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer; the opcode travels in req_tuser.
//   rsp_* returns the results; the status code travels in rsp_tuser and
//   rsp_tlast marks the final result of a command.
//   csr_* writes the expiry age in seconds; csr_ready is always high.
// Operation:
//   An update scans the table one stored route at a time (one memory read,
//   then one compare); on an empty table it appends without a read.
//   A sweep reads each route once and writes survivors back in order.
//   A dump reads one route, places it in the result register, then reads
//   the next; it does not read a route before the last one has been placed.
//   One command is worked on at a time; req_tready is high while idle.
// Reset: empties the table, clears the seconds counter and sets the expiry
//   age to 100. No clearing pass is needed.
// Stall: a result waits in the output register while rsp_tready is low;
//   a dump pauses until each entry has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_table (
   input  wire logic         clock,
   input  wire logic         reset,
   // net_prefix[63:0], gateway_high[127:64], gateway_low[191:128],
   // metric[223:192], direct[224], zero fill [231:225]
   input  wire logic [231:0] req_tdata,
   input  wire logic [1:0]   req_tuser,   // opcode[1:0]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // entry_prefix[63:0], entry_gateway_high[127:64],
   // entry_gateway_low[191:128], entry_metric[223:192], entry_direct[224],
   // entry_age[256:225], route_count[262:257], removed_count[268:263],
   // zero fill [271:269]
   output logic [271:0]      rsp_tdata,
   output logic [3:0]        rsp_tuser,   // status[3:0]
   output logic              rsp_tlast,   // last_item
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [15:0]  csr_data,
   input  wire logic         csr_valid,
   output logic              csr_ready
);
   import dvrt_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   row_type          req_row;
   row_type          rsp_row;
   logic [31:0]      rsp_age;
   logic [CNT_W-1:0] rsp_count, rsp_removed;

   assign csr_ready = 1'b1;

   // unpack request payload
   always_comb begin
      req_row.prefix  = req_tdata[63:0];
      req_row.gw_high = req_tdata[127:64];
      req_row.gw_low  = req_tdata[191:128];
      req_row.metric  = req_tdata[223:192];
      req_row.stamp   = '0;
      req_row.direct  = req_tdata[224];
   end

   dvrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dvrt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_opcode  (req_tuser),
      .req_row     (req_row),
      .csr_we      (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_status  (rsp_tuser),
      .rsp_row     (rsp_row),
      .rsp_age     (rsp_age),
      .rsp_count   (rsp_count),
      .rsp_removed (rsp_removed),
      .rsp_last    (rsp_tlast),
      .cmd         (cmd),
      .sts         (sts)
   );

   // pack result payload
   assign rsp_tdata = {3'd0, rsp_removed, rsp_count, rsp_age, rsp_row.direct,
                       rsp_row.metric, rsp_row.gw_low, rsp_row.gw_high,
                       rsp_row.prefix};

   // busy after a command is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // only dump entries may leave last unset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_ENTRY |-> rsp_tlast)
      else $error("single result without last");

   // route count never exceeds the table size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[262:257] <= CNT_W'(ROUTES))
      else $error("route count out of range");

   // removed count only on sweep results
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_SWEPT |-> rsp_tdata[268:263] == '0)
      else $error("removed count outside sweep");

endmodule

`default_nettype wire

// File: tb/sv/route_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_table_checker
// Watches the command, result and expiry-age channels of the route table.
// Keeps its own copy of the table, works out the results of every accepted
// command and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module route_table_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [231:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [271:0] rsp_tdata,
   input  wire logic [3:0]   rsp_tuser,
   input  wire logic         rsp_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [15:0]  csr_data,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   output int                failures,
   output int                outstanding,
   output int                results_checked
);
   import dvrt_pkg::*;

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] prefix;
      logic [63:0] gw_high;
      logic [63:0] gw_low;
      logic [31:0] metric;
      logic        direct;
      logic [31:0] age;
      logic [5:0]  route_count;
      logic [5:0]  removed_count;
      logic        last;
   } route_result_type;

   route_result_type expected_results[$];

   // shadow of the route table
   logic [63:0] tbl_prefix  [ROUTES];
   logic [63:0] tbl_gw_high [ROUTES];
   logic [63:0] tbl_gw_low  [ROUTES];
   logic [31:0] tbl_metric  [ROUTES];
   logic [31:0] tbl_stamp   [ROUTES];
   logic        tbl_direct  [ROUTES];
   int          route_total;
   logic [31:0] seconds_now;
   logic [15:0] expire_limit;

   function automatic route_result_type blank_result(logic [3:0] st, logic [5:0] removed,
                                                      logic last);
      route_result_type r;
      r = '0;
      r.status        = st;
      r.route_count   = route_total[5:0];
      r.removed_count = removed;
      r.last          = last;
      return r;
   endfunction

   // apply an update to the shadow table and return its status
   function automatic logic [3:0] apply_update(logic [63:0] pfx, logic [63:0] gwh,
                                               logic [63:0] gwl, logic [31:0] met,
                                               logic dir);
      for (int i = 0; i < route_total; i++) begin
         if (tbl_prefix[i] == pfx) begin
            if (met > tbl_metric[i]) return ST_KEPT;
            tbl_gw_high[i] = gwh;
            tbl_gw_low[i]  = gwl;
            tbl_direct[i]  = dir;
            if (met == tbl_metric[i]) return ST_REFRESHED;
            tbl_metric[i] = met;
            tbl_stamp[i]  = seconds_now;
            return ST_REPLACED;
         end
      end
      if (route_total >= ROUTES) return ST_FULL;
      tbl_prefix[route_total]  = pfx;
      tbl_gw_high[route_total] = gwh;
      tbl_gw_low[route_total]  = gwl;
      tbl_metric[route_total]  = met;
      tbl_direct[route_total]  = dir;
      tbl_stamp[route_total]   = seconds_now;
      route_total++;
      return ST_ADDED;
   endfunction

   // drop aged learned routes, keeping the order of survivors
   function automatic int apply_sweep();
      int kept;
      int dropped;
      logic [31:0] age;
      kept    = 0;
      dropped = 0;
      for (int rd = 0; rd < route_total; rd++) begin
         age = seconds_now - tbl_stamp[rd];
         if (!tbl_direct[rd] && age > {16'd0, expire_limit}) begin
            dropped++;
         end else begin
            tbl_prefix[kept]  = tbl_prefix[rd];
            tbl_gw_high[kept] = tbl_gw_high[rd];
            tbl_gw_low[kept]  = tbl_gw_low[rd];
            tbl_metric[kept]  = tbl_metric[rd];
            tbl_stamp[kept]   = tbl_stamp[rd];
            tbl_direct[kept]  = tbl_direct[rd];
            kept++;
         end
      end
      route_total = kept;
      return dropped;
   endfunction

   task automatic predict_command(logic [1:0] op, logic [231:0] d);
      route_result_type r;
      logic [3:0] st;
      int dropped;
      case (op)
         OP_UPDATE: begin
            st = apply_update(d[63:0], d[127:64], d[191:128], d[223:192], d[224]);
            expected_results.push_back(blank_result(st, 6'd0, 1'b1));
         end
         OP_TICK: begin
            seconds_now = seconds_now + 32'd1;
            expected_results.push_back(blank_result(ST_TICK, 6'd0, 1'b1));
         end
         OP_SWEEP: begin
            dropped = apply_sweep();
            expected_results.push_back(blank_result(ST_SWEPT, dropped[5:0], 1'b1));
         end
         default: begin
            if (route_total == 0)
               expected_results.push_back(blank_result(ST_EMPTY, 6'd0, 1'b1));
            for (int i = 0; i < route_total; i++) begin
               r         = blank_result(ST_ENTRY, 6'd0, i == route_total - 1);
               r.prefix  = tbl_prefix[i];
               r.gw_high = tbl_gw_high[i];
               r.gw_low  = tbl_gw_low[i];
               r.metric  = tbl_metric[i];
               r.direct  = tbl_direct[i];
               r.age     = seconds_now - tbl_stamp[i];
               expected_results.push_back(r);
            end
         end
      endcase
   endtask

   task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         failures++;
      end
   endtask

   task automatic check_result();
      route_result_type e;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected result transfer, status %0d", $time, rsp_tuser);
         failures++;
         return;
      end
      e = expected_results.pop_front();
      compare_field("status", e.status, rsp_tuser);
      compare_field("entry_prefix", e.prefix, rsp_tdata[63:0]);
      compare_field("entry_gateway_high", e.gw_high, rsp_tdata[127:64]);
      compare_field("entry_gateway_low", e.gw_low, rsp_tdata[191:128]);
      compare_field("entry_metric", e.metric, rsp_tdata[223:192]);
      compare_field("entry_direct", e.direct, rsp_tdata[224]);
      compare_field("entry_age", e.age, rsp_tdata[256:225]);
      compare_field("route_count", e.route_count, rsp_tdata[262:257]);
      compare_field("removed_count", e.removed_count, rsp_tdata[268:263]);
      compare_field("last_item", e.last, rsp_tlast);
      results_checked++;
   endtask

   initial begin
      failures        = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   // track transfers on all three channels
   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         route_total  = 0;
         seconds_now  = '0;
         expire_limit = EXPIRE_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) expire_limit = csr_data;
         if (req_tvalid && req_tready) predict_command(req_tuser, req_tdata);
      end
      outstanding <= expected_results.size();
   end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives route updates, ticks, sweeps and dumps into the route table under
// varying back-pressure and expiry ages; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import dvrt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 80;

   logic         clock;
   logic         reset;
   logic [231:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [271:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  csr_data;
   logic         csr_valid;
   logic         csr_ready;

   int failures;
   int outstanding;
   int results_checked;
   int commands_sent;
   int cycle_count;
   int send_idle;
   int recv_idle;
   logic [63:0] prefix_pool [40];

   distance_vector_route_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   route_table_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_data        (csr_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .failures        (failures),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // stall the result channel at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[distance_vector_route_table] ERROR");
         $finish;
      end
   end

   // present one command and hold it until the transfer
   task automatic send_command(logic [1:0] op, logic [63:0] pfx, logic [63:0] gwh,
                               logic [63:0] gwl, logic [31:0] met, logic dir);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {7'd0, dir, met, gwl, gwh, pfx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      commands_sent++;
   endtask

   task automatic send_simple(logic [1:0] op);
      send_command(op, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom, 1'($urandom_range(1)));
   endtask

   // hold off until every expected result has come and the block is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_expire(logic [15:0] age);
      drain();
      csr_data  <= age;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // weighted random command; prefixes mostly from a pool so they match
   task automatic random_command();
      int pick;
      logic [63:0] pfx;
      logic [31:0] met;
      pick = $urandom_range(99);
      if (pick < 52) begin
         pfx = ($urandom_range(9) == 0) ? {$urandom, $urandom} : prefix_pool[$urandom_range(39)];
         met = ($urandom_range(9) < 7) ? $urandom_range(0, 6) : $urandom;
         send_command(OP_UPDATE, pfx, {$urandom, $urandom}, {$urandom, $urandom}, met,
                      $urandom_range(3) == 0);
      end else if (pick < 78) begin
         send_simple(OP_TICK);
      end else if (pick < 88) begin
         send_simple(OP_SWEEP);
      end else begin
         send_simple(OP_DUMP);
      end
   endtask

   task automatic random_phase(int s_idle, int r_idle, int count);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int i = 0; i < count; i++) begin
         random_command();
         if (i == count / 2) drain();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_UPDATE;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      commands_sent = 0;
      cycle_count   = 0;
      send_idle     = 17;
      recv_idle     = 63;
      foreach (prefix_pool[i]) prefix_pool[i] = {$urandom, $urandom};
      prefix_pool[0] = '0;
      prefix_pool[1] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dump, field extremes, each metric outcome
      send_simple(OP_DUMP);
      send_command(OP_UPDATE, '1, '1, '1, '1, 1'b1);
      send_command(OP_UPDATE, '0, '0, '0, '0, 1'b0);
      send_command(OP_UPDATE, '1, 64'h0123, 64'h4567, 32'd5, 1'b0);
      send_command(OP_UPDATE, '1, 64'h89ab, 64'hcdef, 32'd5, 1'b1);
      send_command(OP_UPDATE, '1, 64'h1111, 64'h2222, 32'd9, 1'b0);
      send_command(OP_UPDATE, '0, '1, '1, 32'd0, 1'b0);
      send_simple(OP_TICK);
      send_simple(OP_TICK);
      send_simple(OP_DUMP);
      send_simple(OP_SWEEP);
      write_expire(16'd0);
      send_simple(OP_TICK);
      send_simple(OP_SWEEP);
      send_simple(OP_DUMP);
      write_expire(16'hffff);

      // fill the table past its size, then dump all of it
      for (int i = 0; i < 34; i++)
         send_command(OP_UPDATE, prefix_pool[i], {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom_range(0, 6), 1'($urandom_range(1)));
      send_simple(OP_DUMP);
      send_simple(OP_SWEEP);

      random_phase(17, 63, 58);
      write_expire(16'd0);
      random_phase(63, 17, 58);
      write_expire(16'd5);
      random_phase(0, 0, 40);
      write_expire(EXPIRE_RESET);
      random_phase(0, 0, 15);

      drain();
      $display("%0d commands sent, %0d results checked over four expiry ages",
               commands_sent, results_checked);
      $display("back-pressure varied on both channels, table filled, swept and dumped");
      if (failures == 0) begin
         $display("[distance_vector_route_table] OK");
      end else begin
         $display("[distance_vector_route_table] ERROR");
      end
      $finish;
   end

endmodule
